// ===== hw/rtl/tbpr_pkg.sv =====
package tbpr_pkg;

    // default grid geometry and list length
    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 24;
    localparam int LIST_LENGTH_DEF = 5;

    // field and storage widths
    localparam int TEMP_W       = 16;
    localparam int ENTRY_W      = TEMP_W + 1;
    localparam int INDEX_W      = 10;
    localparam int LIST_ENTRY_W = 10;
    localparam int LIST_MAX     = 5;
    localparam int LIST_W       = LIST_ENTRY_W * LIST_MAX;
    localparam int CFG_IDX_W    = 2;
    localparam int SUM_W        = TEMP_W + 2;
    localparam int CNT_W        = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BROKEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER = 2'd1;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // plausibility window and fallback, 1/64 degree
    localparam logic signed [TEMP_W-1:0] LOW_LIMIT    = -16'sd2560;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT   = 16'sd12800;
    localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP = 16'sd1280;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for x below 2^16
    localparam int MAG_W        = 17;
    localparam int RECIP3_SHIFT = 17;
    localparam logic [MAG_W-1:0] RECIP3 = 17'd43691;

    function automatic logic is_plausible(input logic [ENTRY_W-1:0] e);
        logic signed [TEMP_W-1:0] t;
        t = e[TEMP_W-1:0];
        return e[TEMP_W] && (t > LOW_LIMIT) && (t < HIGH_LIMIT);
    endfunction

endpackage

// ===== hw/rtl/tbpr_frame_mem.sv =====
module tbpr_frame_mem #(
    parameter int DEPTH = tbpr_pkg::GRID_WIDTH_DEF * tbpr_pkg::GRID_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [tbpr_pkg::ENTRY_W-1:0] wr_data,
    input  logic [AW-1:0]                rd_addr,
    output logic [tbpr_pkg::ENTRY_W-1:0] rd_data
);

    logic [tbpr_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tbpr_mean_div.sv =====
module tbpr_mean_div (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [tbpr_pkg::SUM_W-1:0]   sum,
    input  logic        [tbpr_pkg::CNT_W-1:0]   count,
    output logic signed [tbpr_pkg::TEMP_W-1:0]  mean
);

    logic                            neg;
    logic [tbpr_pkg::SUM_W-1:0]      mag;
    logic [2*tbpr_pkg::MAG_W-1:0]    prod;
    logic [tbpr_pkg::TEMP_W-1:0]     q;
    logic [tbpr_pkg::TEMP_W-1:0]     q_mag_reg;
    logic                            neg_reg;

    // truncation toward zero: divide the magnitude, restore the sign
    assign neg  = sum[tbpr_pkg::SUM_W-1];
    assign mag  = neg ? tbpr_pkg::SUM_W'(-sum) : tbpr_pkg::SUM_W'(sum);
    assign prod = mag[tbpr_pkg::MAG_W-1:0] * tbpr_pkg::RECIP3;

    always_comb
    begin
        case (count)
            3'd2:    q = mag[tbpr_pkg::TEMP_W:1];
            3'd3:    q = prod[tbpr_pkg::RECIP3_SHIFT +: tbpr_pkg::TEMP_W];
            3'd4:    q = mag[tbpr_pkg::TEMP_W+1:2];
            default: q = mag[tbpr_pkg::TEMP_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_mag_reg <= q;
            neg_reg   <= neg;
        end
    end

    assign mean = neg_reg ? -$signed(q_mag_reg) : $signed(q_mag_reg);

endmodule

// ===== hw/rtl/thermal_bad_pixel_repair.sv =====
// bad pixel repair for a thermal frame held in an on-chip frame store
//
// command channel: an item is taken on a clock edge with start high and busy
// low. a load (req_type 0) writes one pixel; a load with
// frame_end also latches the ambient reading and starts the repair pass.
// a fetch (req_type 1) reads a pixel back: out_valid pulses for one cycle
// in the cycle after the fetch transfer, with out_index and out_temp.
// the receiver cannot stall; a fetch may follow a fetch or a plain load in
// the next cycle, while after a frame_end load busy holds it off
//
// the repair pass holds busy high while it selects each list slot in turn,
// finds row and column of each listed index by repeated subtraction, scans
// every pixel through the single frame store read port, and repairs each
// listed or implausible pixel with four neighbor reads, the mean divide
// and the write back.
//
// config: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 broken list, 1 outlier list); write only while the block is idle.
// reset clears the sequencer, the ambient register and sets both lists to
// none; the frame store holds no reset value and must be loaded first.
module thermal_bad_pixel_repair #(
    parameter int GRID_WIDTH  = tbpr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tbpr_pkg::GRID_HEIGHT_DEF,
    parameter int LIST_LENGTH = tbpr_pkg::LIST_LENGTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic        [tbpr_pkg::INDEX_W-1:0]  pixel_index,
    input  logic signed [tbpr_pkg::TEMP_W-1:0]   temp_value,
    input  logic                                 temp_valid,
    input  logic                                 frame_end,
    input  logic signed [tbpr_pkg::TEMP_W-1:0]   ambient_temp,
    input  logic                                 ambient_valid,
    // results
    output logic                                 out_valid,
    output logic        [tbpr_pkg::INDEX_W-1:0]  out_index,
    output logic signed [tbpr_pkg::TEMP_W-1:0]   out_temp,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [tbpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [tbpr_pkg::LIST_W-1:0]   cfg_data
);

    localparam int GRID_SIZE = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(GRID_SIZE);
    localparam int CW = $clog2(GRID_WIDTH);
    localparam int RW = $clog2(GRID_HEIGHT);
    localparam int KW = (LIST_LENGTH > 1) ? $clog2(LIST_LENGTH) : 1;
    localparam int EW = tbpr_pkg::ENTRY_W;
    localparam int TW = tbpr_pkg::TEMP_W;
    localparam int SW = tbpr_pkg::SUM_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_LIST_SEL = 4'd1;
    localparam logic [3:0] ST_CONV     = 4'd2;
    localparam logic [3:0] ST_SCAN_RD  = 4'd3;
    localparam logic [3:0] ST_SCAN_CHK = 4'd4;
    localparam logic [3:0] ST_NB_RD    = 4'd5;
    localparam logic [3:0] ST_NB_ACC   = 4'd6;
    localparam logic [3:0] ST_DIV      = 4'd7;
    localparam logic [3:0] ST_WR       = 4'd8;

    logic [3:0]                      state_reg, state_next;
    logic [tbpr_pkg::LIST_W-1:0]     broken_list_reg, broken_list_next;
    logic [tbpr_pkg::LIST_W-1:0]     outlier_list_reg, outlier_list_next;
    logic [EW-1:0]                   ambient_reg, ambient_next;
    logic [KW-1:0]                   k_reg, k_next;
    logic                            sel_reg, sel_next;
    logic                            in_scan_reg, in_scan_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [AW-1:0]                   rem_reg, rem_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [1:0]                      nb_reg, nb_next;
    logic                            nb_ok_reg, nb_ok_next;
    logic signed [SW-1:0]            sum_reg, sum_next;
    logic [tbpr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            fetch_oor_reg, fetch_oor_next;
    logic [tbpr_pkg::INDEX_W-1:0]    out_index_reg, out_index_next;

    // frame store port signals
    logic                            mem_wr_en;
    logic [AW-1:0]                   mem_wr_addr;
    logic [EW-1:0]                   mem_wr_data;
    logic [AW-1:0]                   mem_rd_addr;
    logic [EW-1:0]                   mem_rd_data;

    logic                            accept;
    logic                            pixel_in_grid;
    logic [tbpr_pkg::LIST_ENTRY_W-1:0] list_entry;
    logic                            list_entry_ok;
    logic                            nb_in_grid;
    logic [AW-1:0]                   nb_addr;
    logic signed [TW-1:0]            nb_temp;
    logic signed [TW-1:0]            mean;
    logic signed [TW-1:0]            fix_value;
    logic                            div_en;
    logic                            list_last;
    logic                            scan_last;

    assign accept        = start && !busy;
    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign pixel_in_grid = (int'(pixel_index) < GRID_SIZE);

    // list entry k, broken first then outlier
    assign list_entry = sel_reg
        ? outlier_list_reg[tbpr_pkg::LIST_ENTRY_W*k_reg +: tbpr_pkg::LIST_ENTRY_W]
        : broken_list_reg[tbpr_pkg::LIST_ENTRY_W*k_reg +: tbpr_pkg::LIST_ENTRY_W];
    assign list_entry_ok = (int'(list_entry) < GRID_SIZE);
    assign list_last     = sel_reg && (k_reg == KW'(LIST_LENGTH - 1));
    assign scan_last     = (pos_reg == AW'(GRID_SIZE - 1));

    // neighbor order: left, right, up, down
    always_comb
    begin
        case (nb_reg)
            2'd0:
            begin
                nb_in_grid = (col_reg != '0);
                nb_addr    = pos_reg - AW'(1);
            end
            2'd1:
            begin
                nb_in_grid = (col_reg != CW'(GRID_WIDTH - 1));
                nb_addr    = pos_reg + AW'(1);
            end
            2'd2:
            begin
                nb_in_grid = (row_reg != '0);
                nb_addr    = pos_reg - AW'(GRID_WIDTH);
            end
            default:
            begin
                nb_in_grid = (row_reg != RW'(GRID_HEIGHT - 1));
                nb_addr    = pos_reg + AW'(GRID_WIDTH);
            end
        endcase
    end

    assign nb_temp = mem_rd_data[TW-1:0];

    // mean of plausible neighbors, else ambient, else the default
    always_comb
    begin
        if (cnt_reg != '0)
        begin
            fix_value = mean;
        end
        else if (tbpr_pkg::is_plausible(ambient_reg))
        begin
            fix_value = ambient_reg[TW-1:0];
        end
        else
        begin
            fix_value = tbpr_pkg::DEFAULT_TEMP;
        end
    end

    assign div_en = (state_reg == ST_DIV);

    always_comb
    begin
        state_next        = state_reg;
        broken_list_next  = broken_list_reg;
        outlier_list_next = outlier_list_reg;
        ambient_next      = ambient_reg;
        k_next            = k_reg;
        sel_next          = sel_reg;
        in_scan_next      = in_scan_reg;
        pos_next          = pos_reg;
        rem_next          = rem_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        nb_next           = nb_reg;
        nb_ok_next        = nb_ok_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = 1'b0;
        fetch_oor_next    = fetch_oor_reg;
        out_index_next    = out_index_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = AW'(pixel_index);
        mem_wr_data       = {temp_valid, temp_value};
        mem_rd_addr       = pos_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tbpr_pkg::REG_BROKEN:  broken_list_next  = cfg_data;
                tbpr_pkg::REG_OUTLIER: outlier_list_next = cfg_data;
                default:               ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                mem_rd_addr = AW'(pixel_index);
                if (accept)
                begin
                    if (req_type == tbpr_pkg::REQ_FETCH)
                    begin
                        out_valid_next = 1'b1;
                        fetch_oor_next = !pixel_in_grid;
                        out_index_next = pixel_index;
                    end
                    else
                    begin
                        mem_wr_en = pixel_in_grid;
                        if (frame_end)
                        begin
                            ambient_next = {ambient_valid, ambient_temp};
                            k_next       = '0;
                            sel_next     = 1'b0;
                            in_scan_next = 1'b0;
                            state_next   = ST_LIST_SEL;
                        end
                    end
                end
            end

            ST_LIST_SEL:
            begin
                if (list_entry_ok)
                begin
                    pos_next   = AW'(list_entry);
                    rem_next   = AW'(list_entry);
                    row_next   = '0;
                    state_next = ST_CONV;
                end
                else if (list_last)
                begin
                    pos_next     = '0;
                    row_next     = '0;
                    col_next     = '0;
                    in_scan_next = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    sel_next = !sel_reg;
                    if (sel_reg)
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end

            // row and column by repeated subtraction of the grid width
            ST_CONV:
            begin
                if (rem_reg >= AW'(GRID_WIDTH))
                begin
                    rem_next = rem_reg - AW'(GRID_WIDTH);
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next   = rem_reg[CW-1:0];
                    nb_next    = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_NB_RD;
                end
            end

            ST_SCAN_RD:
            begin
                mem_rd_addr = pos_reg;
                state_next  = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (!tbpr_pkg::is_plausible(mem_rd_data))
                begin
                    nb_next    = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_NB_RD;
                end
                else if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + AW'(1);
                    if (col_reg == CW'(GRID_WIDTH - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                    state_next = ST_SCAN_RD;
                end
            end

            ST_NB_RD:
            begin
                mem_rd_addr = nb_in_grid ? nb_addr : pos_reg;
                nb_ok_next  = nb_in_grid;
                state_next  = ST_NB_ACC;
            end

            ST_NB_ACC:
            begin
                if (nb_ok_reg && tbpr_pkg::is_plausible(mem_rd_data))
                begin
                    sum_next = sum_reg + {{(SW-TW){nb_temp[TW-1]}}, nb_temp};
                    cnt_next = cnt_reg + tbpr_pkg::CNT_W'(1);
                end
                nb_next    = nb_reg + 2'd1;
                state_next = (nb_reg == 2'd3) ? ST_DIV : ST_NB_RD;
            end

            ST_DIV:
            begin
                state_next = ST_WR;
            end

            ST_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_reg;
                mem_wr_data = {1'b1, fix_value};
                if (in_scan_reg)
                begin
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + AW'(1);
                        if (col_reg == CW'(GRID_WIDTH - 1))
                        begin
                            col_next = '0;
                            row_next = row_reg + RW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                        state_next = ST_SCAN_RD;
                    end
                end
                else if (list_last)
                begin
                    pos_next     = '0;
                    row_next     = '0;
                    col_next     = '0;
                    in_scan_next = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    sel_next = !sel_reg;
                    if (sel_reg)
                    begin
                        k_next = k_reg + KW'(1);
                    end
                    state_next = ST_LIST_SEL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            broken_list_reg  <= '1;
            outlier_list_reg <= '1;
            ambient_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            broken_list_reg  <= broken_list_next;
            outlier_list_reg <= outlier_list_next;
            ambient_reg      <= ambient_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working registers of the pass and the fetch payload
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        sel_reg       <= sel_next;
        in_scan_reg   <= in_scan_next;
        pos_reg       <= pos_next;
        rem_reg       <= rem_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        nb_reg        <= nb_next;
        nb_ok_reg     <= nb_ok_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        fetch_oor_reg <= fetch_oor_next;
        out_index_reg <= out_index_next;
    end

    tbpr_frame_mem #(
        .DEPTH (GRID_SIZE),
        .AW    (AW)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tbpr_mean_div u_mean_div (
        .clk   (clk),
        .en    (div_en),
        .sum   (sum_reg),
        .count (cnt_reg),
        .mean  (mean)
    );

    // fetch data comes straight off the registered store read
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_temp  = fetch_oor_reg ? '0 : mem_rd_data[TW-1:0];

endmodule
